FILE: hw/rtl/bbm_pkg.sv
// Shared definitions for the bounding box neighbour merge block.
// Holds the operation codes of the shared arithmetic unit and the
// configuration register map. No dependencies.
`default_nettype none

package bbm_pkg;

	localparam int SCORE_W    = 8;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MARGIN_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN_Y = 1'd1;

	localparam logic [CFG_W-1:0] MARGIN_X_RESET = 8'd16;
	localparam logic [CFG_W-1:0] MARGIN_Y_RESET = 8'd0;

	// Operations of the shared axis unit
	typedef enum logic [1:0] {
		OP_WINDOW,  // anchor position + size + margin
		OP_TEST,    // candidate, widened by margin, overlaps the anchor window
		OP_EXTENT,  // far edge of the union
		OP_SPAN     // union size, saturated
	} bbm_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bounding_box_neighbor_merge_top.sv
// Top level of the bounding box neighbour merge: box table, merge sequencer
// and output register. Depends on bbm_pkg and bbm_alu (one per axis).
//
// Rectangles are loaded at one per cycle into a table of MAX_BOXES entries;
// rectangles beyond capacity are dropped and flagged on every result of that
// list. The transaction carrying tlast starts the merge, during which s_tready
// stays low. Each anchor is fetched and its window set up (S_ANCH, S_ALOAD,
// S_WIN), each later entry is tested (S_BRD, S_TEST), and each merge forms
// the union extent and union size and moves the last entry into the freed
// slot (S_EXT, S_SPAN, S_MOVE); the anchor is written back when its scan
// ends, and after any merge the scan restarts from the first entry.
// All of this is bound by the single read port of the table and the shared
// per-axis add/compare unit. Results then leave one at a time, each read
// (S_ERD), registered (S_ELOAD) and held until taken (S_EOUT), and the block
// is ready for the next list in the cycle after the final result.
`default_nettype none

module bounding_box_neighbor_merge_top #(
	parameter int MAX_BOXES  = 64,
	parameter int COORD_BITS = 12,
	localparam int ENT_W   = 4 * COORD_BITS + bbm_pkg::SCORE_W,
	localparam int TDATA_W = ((ENT_W + 7) / 8) * 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [bbm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire [bbm_pkg::CFG_W-1:0]     cfg_data,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// box_left, box_top, box_width, box_height, box_score
	input  wire [TDATA_W-1:0]            s_tdata,
	input  wire                          s_tlast,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// merged_left, merged_top, merged_width, merged_height, merged_score
	output logic [TDATA_W-1:0]           m_tdata,
	output logic                         m_tlast,
	// list_overflow
	output logic [0:0]                   m_tuser
);

	localparam int C     = COORD_BITS;
	localparam int EXT_W = COORD_BITS + 2;
	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [3:0] {
		S_LOAD,
		S_ANCH,
		S_ALOAD,
		S_WIN,
		S_BRD,
		S_TEST,
		S_EXT,
		S_SPAN,
		S_MOVE,
		S_ERD,
		S_ELOAD,
		S_EOUT
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic             ovf_q;
	logic             restart_q;

	logic [bbm_pkg::CFG_W-1:0] margin_x_q;
	logic [bbm_pkg::CFG_W-1:0] margin_y_q;

	logic [ENT_W-1:0] mem [MAX_BOXES];
	logic [ENT_W-1:0] rd_q;

	logic [C-1:0]                a_l_q, a_t_q, a_w_q, a_h_q;
	logic [bbm_pkg::SCORE_W-1:0] a_s_q;
	logic [C-1:0]                win_l_q, win_t_q;
	logic [EXT_W-1:0]            win_ex_q, win_ey_q;
	logic [EXT_W-1:0]            end_x_q, end_y_q;

	logic [C-1:0]                b_l, b_t, b_w, b_h;
	logic [bbm_pkg::SCORE_W-1:0] b_s;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ENT_W-1:0] wr_data;

	bbm_pkg::bbm_op_t alu_op;
	logic [EXT_W-1:0] res_x, res_y;
	logic             hit_x, hit_y;

	logic             room;
	logic [CNT_W-1:0] i_next, j_next, k_next, cnt_last;

	assign b_l = rd_q[C-1:0];
	assign b_t = rd_q[2*C-1:C];
	assign b_w = rd_q[3*C-1:2*C];
	assign b_h = rd_q[4*C-1:3*C];
	assign b_s = rd_q[ENT_W-1:4*C];

	assign room     = (cnt_q < CNT_MAX);
	assign i_next   = i_q + CNT_ONE;
	assign j_next   = j_q + CNT_ONE;
	assign k_next   = k_q + CNT_ONE;
	assign cnt_last = cnt_q - CNT_ONE;

	assign s_tready = (state_q == S_LOAD);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_x_q <= bbm_pkg::MARGIN_X_RESET;
			margin_y_q <= bbm_pkg::MARGIN_Y_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bbm_pkg::REG_MARGIN_X: margin_x_q <= cfg_data;
				bbm_pkg::REG_MARGIN_Y: margin_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		alu_op  = bbm_pkg::OP_TEST;
		unique case (state_q)
			S_LOAD: begin
				wr_en   = s_tvalid && room;
				wr_addr = cnt_q[IDX_W-1:0];
				wr_data = s_tdata[ENT_W-1:0];
			end
			S_ANCH: begin
				rd_en   = (i_next < cnt_q);
				rd_addr = i_q[IDX_W-1:0];
			end
			S_WIN: begin
				alu_op = bbm_pkg::OP_WINDOW;
			end
			S_BRD: begin
				if (j_q < cnt_q) begin
					rd_en   = 1'b1;
					rd_addr = j_q[IDX_W-1:0];
				end else begin
					// anchor finished: write it back
					wr_en   = 1'b1;
					wr_addr = i_q[IDX_W-1:0];
					wr_data = {a_s_q, a_h_q, a_w_q, a_t_q, a_l_q};
				end
			end
			S_EXT: begin
				alu_op = bbm_pkg::OP_EXTENT;
			end
			S_SPAN: begin
				alu_op  = bbm_pkg::OP_SPAN;
				rd_en   = 1'b1;
				rd_addr = cnt_last[IDX_W-1:0];
			end
			S_MOVE: begin
				// move the last active entry into the freed slot
				wr_en   = (j_q != cnt_last);
				wr_addr = j_q[IDX_W-1:0];
				wr_data = rd_q;
			end
			S_ERD: begin
				rd_en   = 1'b1;
				rd_addr = k_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	bbm_alu #(.COORD_BITS(COORD_BITS)) u_alu_x (
		.op       (alu_op),
		.a_pos    (a_l_q),
		.a_size   (a_w_q),
		.b_pos    (b_l),
		.b_size   (b_w),
		.margin   (margin_x_q),
		.win_pos  (win_l_q),
		.win_end  (win_ex_q),
		.span_end (end_x_q),
		.res      (res_x),
		.hit      (hit_x)
	);

	bbm_alu #(.COORD_BITS(COORD_BITS)) u_alu_y (
		.op       (alu_op),
		.a_pos    (a_t_q),
		.a_size   (a_h_q),
		.b_pos    (b_t),
		.b_size   (b_h),
		.margin   (margin_y_q),
		.win_pos  (win_t_q),
		.win_end  (win_ey_q),
		.span_end (end_y_q),
		.res      (res_y),
		.hit      (hit_y)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			ovf_q     <= 1'b0;
			restart_q <= 1'b0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tlast   <= 1'b0;
			m_tuser   <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (s_tvalid) begin
						if (room) begin
							cnt_q <= cnt_q + CNT_ONE;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							i_q     <= '0;
							state_q <= S_ANCH;
						end
					end
				end
				S_ANCH: begin
					if (i_next < cnt_q) begin
						state_q <= S_ALOAD;
					end else begin
						k_q     <= '0;
						state_q <= S_ERD;
					end
				end
				S_ALOAD: begin
					j_q       <= i_next;
					restart_q <= 1'b0;
					state_q   <= S_WIN;
				end
				S_WIN: begin
					state_q <= S_BRD;
				end
				S_BRD: begin
					if (j_q < cnt_q) begin
						state_q <= S_TEST;
					end else begin
						i_q     <= restart_q ? '0 : i_next;
						state_q <= S_ANCH;
					end
				end
				S_TEST: begin
					if (hit_x && hit_y) begin
						state_q <= S_EXT;
					end else begin
						j_q     <= j_next;
						state_q <= S_BRD;
					end
				end
				S_EXT: begin
					state_q <= S_SPAN;
				end
				S_SPAN: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					cnt_q     <= cnt_last;
					j_q       <= j_next;
					restart_q <= 1'b1;
					state_q   <= S_BRD;
				end
				S_ERD: begin
					state_q <= S_ELOAD;
				end
				S_ELOAD: begin
					m_tdata    <= TDATA_W'(rd_q);
					m_tlast    <= (k_next == cnt_q);
					m_tuser[0] <= ovf_q;
					m_tvalid   <= 1'b1;
					state_q    <= S_EOUT;
				end
				S_EOUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_next;
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Anchor and window
	always_ff @(posedge clk) begin
		case (state_q)
			S_ALOAD: begin
				a_l_q <= b_l;
				a_t_q <= b_t;
				a_w_q <= b_w;
				a_h_q <= b_h;
				a_s_q <= b_s;
			end
			S_WIN: begin
				// window stays fixed for the whole scan of this anchor
				win_l_q  <= a_l_q;
				win_t_q  <= a_t_q;
				win_ex_q <= res_x;
				win_ey_q <= res_y;
			end
			S_EXT: begin
				end_x_q <= res_x;
				end_y_q <= res_y;
				a_l_q   <= (b_l < a_l_q) ? b_l : a_l_q;
				a_t_q   <= (b_t < a_t_q) ? b_t : a_t_q;
				a_s_q   <= (b_s > a_s_q) ? b_s : a_s_q;
			end
			S_SPAN: begin
				a_w_q <= res_x[C-1:0];
				a_h_q <= res_y[C-1:0];
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bbm_alu.sv
// Shared add/compare unit for one axis of the merge.
// Depends on bbm_pkg for the operation codes.
`default_nettype none

module bbm_alu #(
	parameter int COORD_BITS = 12,
	localparam int EXT_W = COORD_BITS + 2
) (
	input  var bbm_pkg::bbm_op_t         op,
	input  wire [COORD_BITS-1:0]         a_pos,
	input  wire [COORD_BITS-1:0]         a_size,
	input  wire [COORD_BITS-1:0]         b_pos,
	input  wire [COORD_BITS-1:0]         b_size,
	input  wire [bbm_pkg::CFG_W-1:0]     margin,
	input  wire [COORD_BITS-1:0]         win_pos,
	input  wire [EXT_W-1:0]              win_end,
	input  wire [EXT_W-1:0]              span_end,
	output logic [EXT_W-1:0]             res,
	output logic                         hit
);

	localparam logic [EXT_W-1:0] SIZE_MAX = EXT_W'((1 << COORD_BITS) - 1);

	logic [EXT_W-1:0] a_end;
	logic [EXT_W-1:0] b_end;
	logic [EXT_W-1:0] b_reach;
	logic [EXT_W-1:0] span;

	always_comb begin
		a_end   = EXT_W'(a_pos) + EXT_W'(a_size);
		b_end   = EXT_W'(b_pos) + EXT_W'(b_size);
		b_reach = b_end + EXT_W'(margin);
		span    = span_end - EXT_W'(a_pos);
		res     = '0;
		hit     = 1'b0;
		unique case (op)
			bbm_pkg::OP_WINDOW: begin
				res = a_end + EXT_W'(margin);
			end
			bbm_pkg::OP_TEST: begin
				// left edge of window minus candidate size and margin <= corner <= right edge
				hit = (b_reach >= EXT_W'(win_pos)) && (EXT_W'(b_pos) <= win_end);
			end
			bbm_pkg::OP_EXTENT: begin
				res = (a_end > b_end) ? a_end : b_end;
			end
			bbm_pkg::OP_SPAN: begin
				res = (span > SIZE_MAX) ? SIZE_MAX : span;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bbm_checker.sv
// Port-level checks for the bounding box neighbour merge top level.
// Attached to bounding_box_neighbor_merge_top by the bind at the end.
`default_nettype none

module bbm_checker #(
	parameter int TDATA_W = 56
) (
	input wire               clk,
	input wire               arst_n,
	input wire               s_tvalid,
	input wire               s_tready,
	input wire               s_tlast,
	input wire               m_tvalid,
	input wire               m_tready,
	input wire [TDATA_W-1:0] m_tdata,
	input wire               m_tlast,
	input wire [0:0]         m_tuser
);

	// Input is never taken while a result is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	// Closing input transaction starts the merge and drops ready
	a_merge_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("ready still high after the final input transaction");

	// Final result hands the block back to loading
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block not ready after the final result");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind bounding_box_neighbor_merge_top bbm_checker #(.TDATA_W(TDATA_W)) u_bbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
